// ===== hw/rtl/fir_filter_block_mean_defines.svh =====
// Assertion shorthands for the block-mean FIR filter.
// Each check samples on the rising edge of clk and is off while rst is high.
`ifndef FIR_FILTER_BLOCK_MEAN_DEFINES_SVH
`define FIR_FILTER_BLOCK_MEAN_DEFINES_SVH

// Condition must hold at every edge outside reset.
`define FBM_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("fir_filter_block_mean: invariant violated");

// When the antecedent holds, the consequent must hold in the same cycle.
`define FBM_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fir_filter_block_mean: implication violated");

`endif

// ===== hw/rtl/fbm_pkg.sv =====
`default_nettype none

package fbm_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int WEIGHT_W    = 16;
  localparam int PROD_W      = 32;
  localparam int SUM_W       = 42;
  localparam int NUM_WEIGHTS = 5;

  // Configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Mean divider: magnitude after dropping the Q1.15 weight scale,
  // reciprocal width, quotient width and remainder width.
  localparam int RECIP_SHIFT = 32;
  localparam int MAG_W       = 27;
  localparam int RECIP_W     = 31;
  localparam int QUO_W       = MAG_W + RECIP_W - RECIP_SHIFT;
  localparam int REM_W       = 7;

  // Saturation bounds of the mean magnitude
  localparam int POS_LIMIT = 32767;
  localparam int NEG_LIMIT = 32768;
  localparam logic signed [SAMPLE_W-1:0] MEAN_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] MEAN_MIN = 16'sh8000;

  typedef enum logic [2:0] {
    REG_WEIGHT_0 = 3'd0,
    REG_WEIGHT_1 = 3'd1,
    REG_WEIGHT_2 = 3'd2,
    REG_WEIGHT_3 = 3'd3,
    REG_WEIGHT_4 = 3'd4
  } reg_index_t;

  typedef logic signed [WEIGHT_W-1:0] weight_t;

  localparam weight_t WEIGHT_RESET [NUM_WEIGHTS] = '{
    16'sd3277, 16'sd4915, 16'sd16384, 16'sd4915, 16'sd3277
  };

endpackage

`default_nettype wire

// ===== hw/rtl/fir_filter_block_mean.sv =====
// Block-averaged FIR filter for signed Q.4 temperature samples. Every window of
// TAPS consecutive samples inside a block of BLOCK_LEN samples is weighted by
// the Q1.15 weights weight_0..weight_(TAPS-1) (the highest one on the newest
// sample) and summed exactly; the final sample of a block yields one beat with
// the mean of the BLOCK_LEN-TAPS+1 filtered values in Q.4, truncated toward
// zero, saturated to 16 bits with clipped set when it had to be limited. All
// other samples yield no beat. Samples are taken one per clock unless held off
// by sample_stall: the five weight multiplies sit between the sample input and
// history line and a product register, and the add tree plus accumulator
// follow in the next cycle. After the final sample of a block is taken, its
// mean beat passes through a fixed-point reciprocal multiply and a one-step
// remainder correction to the output register. The final sample of a block
// is held off (sample_stall) only while the previous block's mean is still in
// that path or has not been taken from the output register. Weights are
// written over the APB port at byte address 4*i, read back sign-extended, and
// must only be changed while the block is idle.
`default_nettype none
`include "fir_filter_block_mean_defines.svh"

module fir_filter_block_mean #(
  parameter int TAPS      = 5,
  parameter int BLOCK_LEN = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [fbm_pkg::ADDR_W-1:0]            paddr,
  input  logic [fbm_pkg::DATA_W-1:0]            pwdata,
  output logic [fbm_pkg::DATA_W-1:0]            prdata,
  output logic                                  pready,
  // sample channel
  input  logic signed [fbm_pkg::SAMPLE_W-1:0]   sample,
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  // mean channel
  output logic signed [fbm_pkg::SAMPLE_W-1:0]   block_mean,
  output logic                                  clipped,
  output logic                                  mean_valid,
  input  logic                                  mean_stall
);

  localparam int CNT_W  = $clog2(BLOCK_LEN);
  localparam int HIST_D = TAPS - 1;
  localparam int DIV_N  = BLOCK_LEN - TAPS + 1;

  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(BLOCK_LEN - 1);
  localparam logic [CNT_W-1:0] WIN_POS  = CNT_W'(TAPS - 1);

  // floor(2^32 / DIV_N); the estimate it gives is at most one below the
  // true quotient for any magnitude below 2^27.
  localparam logic [63:0] RECIP_FULL = 64'h1_0000_0000 / 64'(DIV_N);
  localparam logic [fbm_pkg::RECIP_W-1:0] RECIP = RECIP_FULL[fbm_pkg::RECIP_W-1:0];
  localparam logic [fbm_pkg::REM_W-1:0]   DIV_N_REM = fbm_pkg::REM_W'(DIV_N);
  localparam logic [fbm_pkg::MAG_W-1:0]   DIV_N_MAG = fbm_pkg::MAG_W'(DIV_N);

  // ---------------------------------------------------------------------------
  // Weight registers and APB access
  // ---------------------------------------------------------------------------
  fbm_pkg::weight_t weights [fbm_pkg::NUM_WEIGHTS];

  logic       cfg_write;
  logic [2:0] reg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign reg_sel   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fbm_pkg::NUM_WEIGHTS; i++) begin
        weights[i] <= fbm_pkg::WEIGHT_RESET[i];
      end
    end else if (cfg_write) begin
      case (reg_sel)
        fbm_pkg::REG_WEIGHT_0: weights[0] <= pwdata[fbm_pkg::WEIGHT_W-1:0];
        fbm_pkg::REG_WEIGHT_1: weights[1] <= pwdata[fbm_pkg::WEIGHT_W-1:0];
        fbm_pkg::REG_WEIGHT_2: weights[2] <= pwdata[fbm_pkg::WEIGHT_W-1:0];
        fbm_pkg::REG_WEIGHT_3: weights[3] <= pwdata[fbm_pkg::WEIGHT_W-1:0];
        fbm_pkg::REG_WEIGHT_4: weights[4] <= pwdata[fbm_pkg::WEIGHT_W-1:0];
        default: ;  // writes past the last weight are dropped
      endcase
    end
  end

  // Read back sign-extended
  always_comb begin
    case (reg_sel)
      fbm_pkg::REG_WEIGHT_0: prdata = fbm_pkg::DATA_W'(weights[0]);
      fbm_pkg::REG_WEIGHT_1: prdata = fbm_pkg::DATA_W'(weights[1]);
      fbm_pkg::REG_WEIGHT_2: prdata = fbm_pkg::DATA_W'(weights[2]);
      fbm_pkg::REG_WEIGHT_3: prdata = fbm_pkg::DATA_W'(weights[3]);
      fbm_pkg::REG_WEIGHT_4: prdata = fbm_pkg::DATA_W'(weights[4]);
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sample intake: position in block, history line
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]                       count;
  logic signed [fbm_pkg::SAMPLE_W-1:0]    history [HIST_D];
  logic                                   accept;
  logic                                   is_last;
  logic                                   window_full;
  logic                                   result_busy;

  // Result-path occupancy signals, declared here for the stall term
  logic prod_valid;
  logic prod_last;
  logic s1_v;
  logic s2_v;
  logic s3_v;
  logic s4_v;

  assign is_last     = (count == LAST_POS);
  assign window_full = (count >= WIN_POS);
  assign result_busy = prod_last | s1_v | s2_v | s3_v | s4_v | mean_valid;

  // Only the block-closing beat waits, and only on the previous mean
  assign sample_stall = is_last & result_busy;
  assign accept       = sample_valid & ~sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= is_last ? '0 : count + 1'b1;
    end
  end

  // Entries are always refilled before a window of the new block reads them,
  // so the line needs no clearing at a block boundary.
  always_ff @(posedge clk) begin
    if (accept) begin
      history[0] <= sample;
      for (int i = 1; i < HIST_D; i++) begin
        history[i] <= history[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Window products: tap j pairs weight j with the (TAPS-1-j)-th older sample
  // ---------------------------------------------------------------------------
  logic signed [fbm_pkg::SAMPLE_W-1:0] tap_in [TAPS];
  logic signed [fbm_pkg::PROD_W-1:0]   prod   [TAPS];

  for (genvar j = 0; j < TAPS; j++) begin : g_tap
    if (j == TAPS - 1) begin : g_newest
      assign tap_in[j] = sample;
    end else begin : g_older
      assign tap_in[j] = history[TAPS-2-j];
    end

    always_ff @(posedge clk) begin
      if (accept) begin
        prod[j] <= tap_in[j] * weights[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      prod_last  <= 1'b0;
    end else begin
      prod_valid <= accept & window_full;
      prod_last  <= accept & is_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Accumulate: add tree over the products, then into the running sum
  // ---------------------------------------------------------------------------
  logic signed [fbm_pkg::SUM_W-1:0] filtered_sum;
  logic signed [fbm_pkg::SUM_W-1:0] tap_sum;
  logic signed [fbm_pkg::SUM_W-1:0] sum_next;

  always_comb begin
    tap_sum = '0;
    for (int j = 0; j < TAPS; j++) begin
      tap_sum = tap_sum + fbm_pkg::SUM_W'(prod[j]);
    end
  end

  assign sum_next = prod_valid ? (filtered_sum + tap_sum) : filtered_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_sum <= '0;
    end else if (prod_last) begin
      filtered_sum <= '0;  // block closes: start the next one from zero
    end else if (prod_valid) begin
      filtered_sum <= sum_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Mean path: divide by DIV_N * 2^15, truncated toward zero
  // ---------------------------------------------------------------------------
  logic signed [fbm_pkg::SUM_W-1:0]        s1_sum;
  logic [fbm_pkg::SUM_W-1:0]               s1_abs;
  logic                                    s2_neg;
  logic [fbm_pkg::MAG_W-1:0]               s2_mag;
  logic [fbm_pkg::MAG_W+fbm_pkg::RECIP_W-1:0] s2_full;
  logic                                    s3_neg;
  logic [fbm_pkg::MAG_W-1:0]               s3_mag;
  logic [fbm_pkg::QUO_W-1:0]               s3_q;
  logic [fbm_pkg::MAG_W-1:0]               s3_rem;
  logic                                    s4_neg;
  logic [fbm_pkg::QUO_W-1:0]               s4_q;
  logic [fbm_pkg::REM_W-1:0]               s4_rem;
  logic [fbm_pkg::QUO_W-1:0]               q_fix;
  logic                                    clip_next;
  logic signed [fbm_pkg::SAMPLE_W-1:0]     mean_next;

  // Stage 1: final block sum
  always_ff @(posedge clk) begin
    if (prod_last) begin
      s1_sum <= sum_next;
    end
  end

  // Stage 2: sign and magnitude with the Q1.15 scale dropped
  assign s1_abs = s1_sum[fbm_pkg::SUM_W-1] ? -s1_sum : s1_sum;

  always_ff @(posedge clk) begin
    if (s1_v) begin
      s2_neg <= s1_sum[fbm_pkg::SUM_W-1];
      s2_mag <= s1_abs[fbm_pkg::SUM_W-1:fbm_pkg::SUM_W-fbm_pkg::MAG_W];
    end
  end

  // Stage 3: quotient estimate by reciprocal multiply
  assign s2_full = s2_mag * RECIP;

  always_ff @(posedge clk) begin
    if (s2_v) begin
      s3_neg <= s2_neg;
      s3_mag <= s2_mag;
      s3_q   <= s2_full[fbm_pkg::MAG_W+fbm_pkg::RECIP_W-1:fbm_pkg::RECIP_SHIFT];
    end
  end

  // Stage 4: remainder of the estimate; it stays below twice the divisor
  assign s3_rem = s3_mag - fbm_pkg::MAG_W'(s3_q) * DIV_N_MAG;

  always_ff @(posedge clk) begin
    if (s3_v) begin
      s4_neg <= s3_neg;
      s4_q   <= s3_q;
      s4_rem <= s3_rem[fbm_pkg::REM_W-1:0];
    end
  end

  // Stage 5: correct by one, restore sign, saturate
  always_comb begin
    q_fix = s4_q + fbm_pkg::QUO_W'(s4_rem >= DIV_N_REM);
    if (s4_neg) begin
      clip_next = (q_fix > fbm_pkg::QUO_W'(fbm_pkg::NEG_LIMIT));
      mean_next = clip_next ? fbm_pkg::MEAN_MIN : -q_fix[fbm_pkg::SAMPLE_W-1:0];
    end else begin
      clip_next = (q_fix > fbm_pkg::QUO_W'(fbm_pkg::POS_LIMIT));
      mean_next = clip_next ? fbm_pkg::MEAN_MAX : q_fix[fbm_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
    end else begin
      s1_v <= prod_last;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
    end
  end

  // Output register: the stall rule keeps it empty whenever stage 4 delivers
  always_ff @(posedge clk) begin
    if (rst) begin
      mean_valid <= 1'b0;
    end else if (s4_v) begin
      mean_valid <= 1'b1;
    end else if (!mean_stall) begin
      mean_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_v) begin
      block_mean <= mean_next;
      clipped    <= clip_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // At most one block mean is ever in flight or waiting
  `FBM_ALWAYS(a_single_mean_in_flight,
    $countones({prod_last, s1_v, s2_v, s3_v, s4_v, mean_valid}) <= 1)

  // A fresh block starts from an empty sum
  `FBM_IMPLIES(a_fresh_block_sum_clear, (count == '0) && !prod_last,
    filtered_sum == '0)

  // A clipped mean sits on one of the two limits
  `FBM_IMPLIES(a_clip_on_limit, mean_valid && clipped,
    (block_mean == fbm_pkg::MEAN_MAX) || (block_mean == fbm_pkg::MEAN_MIN))

  // The intake holds off only the block-closing beat, and only while busy
  `FBM_IMPLIES(a_stall_only_at_close, sample_stall, is_last && result_busy)

endmodule

`default_nettype wire

// ===== bench/fbm_mean_checker.sv =====
module fbm_mean_checker #(
  parameter int TAPS      = 5,
  parameter int BLOCK_LEN = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [fbm_pkg::ADDR_W-1:0]           paddr,
  input  logic [fbm_pkg::DATA_W-1:0]           pwdata,
  input  logic [fbm_pkg::DATA_W-1:0]           prdata,
  input  logic                                 pready,
  input  logic signed [fbm_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                 sample_valid,
  input  logic                                 sample_stall,
  input  logic signed [fbm_pkg::SAMPLE_W-1:0]  block_mean,
  input  logic                                 clipped,
  input  logic                                 mean_valid,
  input  logic                                 mean_stall,
  output int                                   failures,
  output int                                   outstanding,
  output int                                   means_seen,
  output int                                   clips_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int    DATA_W       = fbm_pkg::DATA_W;
  localparam longint WEIGHT_SCALE = longint'(1) << (fbm_pkg::WEIGHT_W - 1);

  typedef struct packed {
    logic signed [fbm_pkg::SAMPLE_W-1:0] mean;
    logic                                clip;
  } mean_beat_t;

  mean_beat_t                          pending_means [$];
  fbm_pkg::weight_t                    coeff [fbm_pkg::NUM_WEIGHTS];
  logic signed [fbm_pkg::SAMPLE_W-1:0] recent [fbm_pkg::NUM_WEIGHTS-1];
  int                                  taken = 0;
  longint                              window_sum = 0;
  int                                  fail_count = 0;
  int                                  pending_count = 0;
  int                                  mean_count = 0;
  int                                  clip_count = 0;
  logic [fbm_pkg::ADDR_W-3:0]          slot;

  assign failures    = fail_count;
  assign outstanding = pending_count;
  assign means_seen  = mean_count;
  assign clips_seen  = clip_count;
  assign slot        = paddr[fbm_pkg::ADDR_W-1:2];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns  %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic clear_block();
    window_sum = 0;
    taken = 0;
    foreach (recent[k]) recent[k] = '0;
  endtask

  // Fold one sample into the block; queue the mean when the block closes.
  task automatic fold_sample(input logic signed [fbm_pkg::SAMPLE_W-1:0] x);
    longint     window;
    longint     quotient;
    mean_beat_t beat;
    if (taken + 1 >= TAPS) begin
      window = longint'(coeff[TAPS-1]) * longint'(x);
      for (int k = 1; k < TAPS; k++)
        window += longint'(coeff[TAPS-1-k]) * longint'(recent[k-1]);
      window_sum += window;
    end
    if (taken + 1 >= BLOCK_LEN) begin
      quotient  = window_sum / (longint'(BLOCK_LEN - TAPS + 1) * WEIGHT_SCALE);
      beat.clip = 1'b0;
      if (quotient > fbm_pkg::POS_LIMIT) begin
        beat.mean = fbm_pkg::MEAN_MAX;
        beat.clip = 1'b1;
      end else if (quotient < -fbm_pkg::NEG_LIMIT) begin
        beat.mean = fbm_pkg::MEAN_MIN;
        beat.clip = 1'b1;
      end else begin
        beat.mean = 16'(quotient);
      end
      pending_means.push_back(beat);
      clear_block();
    end else begin
      for (int k = TAPS - 2; k > 0; k--) recent[k] = recent[k-1];
      recent[0] = x;
      taken++;
    end
  endtask

  always @(posedge clk) begin
    mean_beat_t want;
    if (rst) begin
      coeff = fbm_pkg::WEIGHT_RESET;
      clear_block();
      pending_means.delete();
    end else begin
      if (psel && penable && pready && slot < fbm_pkg::NUM_WEIGHTS) begin
        if (pwrite)
          coeff[slot] = pwdata[fbm_pkg::WEIGHT_W-1:0];
        else if (prdata !== DATA_W'(coeff[slot]))
          report_mismatch("weight readback", int'(prdata), int'(coeff[slot]));
      end
      if (sample_valid && !sample_stall)
        fold_sample(sample);
      if (mean_valid && !mean_stall) begin
        if (pending_means.size() == 0) begin
          report_mismatch("mean beat with no block closed", int'(block_mean), 0);
        end else begin
          want = pending_means.pop_front();
          if (block_mean !== want.mean)
            report_mismatch("block_mean", int'(block_mean), int'(want.mean));
          if (clipped !== want.clip)
            report_mismatch("clipped", int'(clipped), int'(want.clip));
          mean_count++;
          if (want.clip) clip_count++;
        end
      end
    end
    pending_count = pending_means.size();
  end

endmodule

// ===== bench/tb_fir_filter_block_mean.sv =====
module tb_fir_filter_block_mean;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS         = 5;
  localparam int BLOCK_LEN    = 64;
  localparam int ADDR_W       = fbm_pkg::ADDR_W;
  localparam int SAMPLE_W     = fbm_pkg::SAMPLE_W;
  localparam int ADDR_SLOTS   = 1 << (ADDR_W - 2);
  localparam int IDLE_PERCENT = 17;
  localparam int RANDOM_ITEMS = 1900;
  // the mean leaves through the result path after the closing sample; allow generous slack
  localparam int DRAIN_CYCLES = 20;
  // quiet cycles before giving up: far above any stall or gap streak
  localparam int QUIET_LIMIT  = 2000;
  localparam int EXTREME_LEN  = 140;
  localparam int CALM_LEN     = 400;

  typedef enum {FEED_MAX, FEED_MIN, FEED_FULL, FEED_TEMP, FEED_CORNER} feed_t;
  typedef enum {W_MAX, W_MIN, W_ZERO, W_RESET, W_ALTERNATE, W_RANDOM} weight_set_t;

  // Opening corner pass: extremes, sign boundaries and alternating bit patterns.
  localparam logic signed [SAMPLE_W-1:0] CORNER_SAMPLES [25] = '{
    16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001,
    16'sh5555, 16'shAAAA, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
    16'sh8000, 16'sh0010, 16'shFFF0, 16'sh0100, 16'shFF00,
    16'sh1000, 16'shF000, 16'sh7FFE, 16'sh8001, 16'sh0640,
    16'shFCE0, 16'sh00FF, 16'shFF01, 16'sh0000, 16'sh7FFF
  };

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [ADDR_W-1:0]             paddr = '0;
  logic [fbm_pkg::DATA_W-1:0]    pwdata = '0;
  logic [fbm_pkg::DATA_W-1:0]    prdata;
  logic                          pready;
  logic signed [SAMPLE_W-1:0]    sample = '0;
  logic                          sample_valid = 1'b0;
  logic                          sample_stall;
  logic signed [SAMPLE_W-1:0]    block_mean;
  logic                          clipped;
  logic                          mean_valid;
  logic                          mean_stall = 1'b0;

  int failures;
  int outstanding;
  int means_seen;
  int clips_seen;

  bit sender_gaps = 1'b1;
  bit receiver_stalls = 1'b1;
  int samples_sent = 0;
  int random_sent = 0;
  int reg_writes = 0;
  int phases_run = 0;
  int quiet_cycles = 0;

  fir_filter_block_mean #(
    .TAPS      (TAPS),
    .BLOCK_LEN (BLOCK_LEN)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .block_mean   (block_mean),
    .clipped      (clipped),
    .mean_valid   (mean_valid),
    .mean_stall   (mean_stall)
  );

  // Watches both channels and the register port, predicts every block mean.
  fbm_mean_checker #(
    .TAPS      (TAPS),
    .BLOCK_LEN (BLOCK_LEN)
  ) mean_check (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .block_mean   (block_mean),
    .clipped      (clipped),
    .mean_valid   (mean_valid),
    .mean_stall   (mean_stall),
    .failures     (failures),
    .outstanding  (outstanding),
    .means_seen   (means_seen),
    .clips_seen   (clips_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Randomly hold the mean channel; drop the stalls during the calm stretch.
  always @(negedge clk)
    mean_stall <= receiver_stalls && ($urandom_range(0, 99) < IDLE_PERCENT);

  // Abort when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (mean_valid && !mean_stall) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Timed out: no beat for %0d cycles, %0d means still owed",
               QUIET_LIMIT, outstanding);
      $display("tb_fir_filter_block_mean NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one sample beat, with a random gap ahead of it when gaps are on.
  // Valid stays high on return so back-to-back beats never drop it.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    while (sender_gaps && $urandom_range(0, 99) < IDLE_PERCENT) begin
      sample_valid <= 1'b0;
      sample       <= SAMPLE_W'($urandom);
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= value;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    @(negedge clk);
    samples_sent++;
  endtask

  // Hold the sender until every owed mean has arrived, then let the
  // pipeline drain any partial-block work before touching the weights.
  task automatic settle();
    sample_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One register access: setup cycle, access cycle, then psel is held low before
  // returning so the next access never re-raises psel in the step that lowers it.
  task automatic reg_access(input bit write, input int index,
                            input logic [fbm_pkg::DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= ADDR_W'(index * 4);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    if (write) reg_writes++;
  endtask

  function automatic logic [fbm_pkg::WEIGHT_W-1:0] pick_weight(input weight_set_t set,
                                                               input int index);
    case (set)
      W_MAX:       pick_weight = 16'h7FFF;
      W_MIN:       pick_weight = 16'h8000;
      W_ZERO:      pick_weight = 16'h0000;
      W_RESET:     pick_weight = fbm_pkg::WEIGHT_RESET[index];
      W_ALTERNATE: pick_weight = index[0] ? 16'h8000 : 16'h7FFF;
      default:     pick_weight = 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input feed_t feed);
    case (feed)
      FEED_MAX:  pick_sample = 16'sh7FFF;
      FEED_MIN:  pick_sample = 16'sh8000;
      // plausible room temperatures, -50 to +100 degrees in Q.4
      FEED_TEMP: pick_sample = SAMPLE_W'($urandom_range(0, 2400) - 800);
      FEED_CORNER: begin
        case ($urandom_range(0, 4))
          0:       pick_sample = 16'sh7FFF;
          1:       pick_sample = 16'sh8000;
          2:       pick_sample = 16'sh0000;
          3:       pick_sample = 16'shFFFF;
          default: pick_sample = 16'sh0001;
        endcase
      end
      default:   pick_sample = SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    weight_set_t wset;
    feed_t       feed;
    int          run_len;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Read every slot after reset; unused slots are read but not judged.
    for (int i = 0; i < ADDR_SLOTS; i++) reg_access(1'b0, i, '0);

    // Corner samples at the reset weights; this block stays open.
    foreach (CORNER_SAMPLES[k]) send_sample(CORNER_SAMPLES[k]);
    settle();

    // Writes past the last weight must leave everything unchanged.
    for (int i = fbm_pkg::REG_WEIGHT_4 + 1; i < ADDR_SLOTS; i++)
      reg_access(1'b1, i, $urandom);

    // Phases: new weights, then a run of samples. The first four pair extreme
    // weights with constant extreme samples to saturate in both directions;
    // the fifth is a long calm stretch with no gaps and no stalls.
    for (int phase = 0; random_sent < RANDOM_ITEMS; phase++) begin
      if (phase < 4) begin
        wset    = (phase < 2) ? W_MAX : W_MIN;
        feed    = phase[0] ? FEED_MIN : FEED_MAX;
        run_len = EXTREME_LEN;
      end else if (phase == 4) begin
        wset    = W_RESET;
        feed    = FEED_TEMP;
        run_len = CALM_LEN;
      end else if (phase == 5) begin
        wset    = W_ZERO;
        feed    = FEED_FULL;
        run_len = $urandom_range(40, 220);
      end else begin
        wset    = weight_set_t'($urandom_range(W_MAX, W_RANDOM));
        feed    = feed_t'($urandom_range(FEED_MAX, FEED_CORNER));
        run_len = $urandom_range(40, 220);
      end

      // Upper data bits are random and must be ignored by the weight.
      for (int i = fbm_pkg::REG_WEIGHT_0; i <= fbm_pkg::REG_WEIGHT_4; i++)
        reg_access(1'b1, i, {16'($urandom), pick_weight(wset, i)});
      for (int i = fbm_pkg::REG_WEIGHT_0; i <= fbm_pkg::REG_WEIGHT_4; i++)
        reg_access(1'b0, i, '0);

      sender_gaps     = (phase != 4);
      receiver_stalls = (phase != 4);
      repeat (run_len) send_sample(pick_sample(feed));
      random_sent += run_len;
      phases_run++;
      settle();
    end

    receiver_stalls = 1'b1;
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d samples over %0d weight settings with %0d register writes",
             samples_sent, phases_run + 1, reg_writes);
    $display("Compared %0d block means, %0d of them saturated; %0d mismatches",
             means_seen, clips_seen, failures);
    if (failures == 0)
      $display("tb_fir_filter_block_mean OK");
    else
      $display("tb_fir_filter_block_mean NOT OK");
    $finish;
  end

endmodule
